>>> hw/rtl/lcc_pkg.sv
// ----------------------------------------------------------------------------
// lcc_pkg
// Shared types and constants of the mod-10 card number classifier.
// ----------------------------------------------------------------------------
package lcc_pkg;

  localparam int CARD_W       = 63;
  localparam int MAX_DIGITS   = 19;
  localparam int NUM_BCD      = 19;
  localparam int BCD_W        = 4 * NUM_BCD;
  localparam int BIN_W        = 64;
  localparam int BITS_PER_CYC = 4;
  localparam int CONV_STEPS   = BIN_W / BITS_PER_CYC;
  localparam int CONV_CNT_W   = $clog2(CONV_STEPS);
  localparam int IDX_W        = $clog2(NUM_BCD);
  localparam int COUNT_W      = 5;

  localparam logic [COUNT_W-1:0] COUNT_13  = COUNT_W'(13);
  localparam logic [COUNT_W-1:0] COUNT_15  = COUNT_W'(15);
  localparam logic [COUNT_W-1:0] COUNT_16  = COUNT_W'(16);
  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_DIGITS);

  typedef enum logic [1:0] {
    CLS_INVALID,
    CLS_FIFTEEN,
    CLS_SIXTEEN,
    CLS_LEAD4
  } card_class_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_WALK,
    ST_DONE
  } lcc_state_t;

  typedef struct packed {
    logic load;
    logic dabble;
    logic shr;
  } conv_ctl_t;

  typedef struct packed {
    logic               ovf;
    logic [3:0]         mod;
    logic [COUNT_W-1:0] count;
    logic [3:0]         lead1;
    logic [3:0]         lead2;
  } luhn_res_t;

endpackage

>>> hw/rtl/lcc_bcd_conv.sv
// ----------------------------------------------------------------------------
// lcc_bcd_conv
// Iterative binary to bcd converter, four shift-add-3 steps per cycle,
// then a digit shifter that hands out one digit per cycle, lsd first.
// ----------------------------------------------------------------------------
module lcc_bcd_conv (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lcc_pkg::conv_ctl_t        ctl,
  input  logic [lcc_pkg::CARD_W-1:0] card_number,
  output logic [3:0]                digit,
  output logic                      conv_last
);
  import lcc_pkg::*;

  logic [BIN_W-1:0]      bin_r, bin_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt;
  logic [CONV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [BIN_W-1:0]      bin_t;
  logic [BCD_W-1:0]      bcd_t;

  always_comb begin
    bcd_t = bcd_r;
    bin_t = bin_r;
    for (int k = 0; k < BITS_PER_CYC; k++) begin
      for (int j = 0; j < NUM_BCD; j++) begin
        if (bcd_t[j*4 +: 4] >= 4'd5) begin
          bcd_t[j*4 +: 4] = bcd_t[j*4 +: 4] + 4'd3;
        end
      end
      {bcd_t, bin_t} = {bcd_t[BCD_W-2:0], bin_t, 1'b0};
    end
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    cnt_nxt = cnt_r;
    if (ctl.load) begin
      bin_nxt = {1'b0, card_number};
      bcd_nxt = '0;
      cnt_nxt = '0;
    end else if (ctl.dabble) begin
      bin_nxt = bin_t;
      bcd_nxt = bcd_t;
      cnt_nxt = cnt_r + 1'b1;
    end else if (ctl.shr) begin
      bcd_nxt = {4'd0, bcd_r[BCD_W-1:4]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign digit     = bcd_r[3:0];
  assign conv_last = ctl.dabble && (cnt_r == CONV_CNT_W'(CONV_STEPS - 1));

endmodule

>>> hw/rtl/lcc_digit_walk.sv
// ----------------------------------------------------------------------------
// lcc_digit_walk
// Per-digit luhn accumulator: doubles odd positions, keeps the sum mod ten,
// tracks digit count, leading two digits and excess digits.
// ----------------------------------------------------------------------------
module lcc_digit_walk (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               step,
  input  logic [3:0]         digit,
  output lcc_pkg::luhn_res_t res,
  output logic               walk_last
);
  import lcc_pkg::*;

  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [3:0]         mod_r, mod_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [3:0]         lead1_r, lead1_nxt;
  logic [3:0]         lead2_r, lead2_nxt;
  logic [3:0]         prev_r, prev_nxt;
  logic               ovf_r, ovf_nxt;
  logic [4:0]         dbl;
  logic [4:0]         w;
  logic [4:0]         s;

  always_comb begin
    dbl = {digit, 1'b0};
    if (dbl > 5'd9) begin
      dbl = dbl - 5'd9;
    end
    w = idx_r[0] ? dbl : {1'b0, digit};
    s = {1'b0, mod_r} + w;
  end

  always_comb begin
    idx_nxt   = idx_r;
    mod_nxt   = mod_r;
    cnt_nxt   = cnt_r;
    lead1_nxt = lead1_r;
    lead2_nxt = lead2_r;
    prev_nxt  = prev_r;
    ovf_nxt   = ovf_r;
    if (start) begin
      idx_nxt   = '0;
      mod_nxt   = '0;
      cnt_nxt   = '0;
      lead1_nxt = '0;
      lead2_nxt = '0;
      prev_nxt  = '0;
      ovf_nxt   = 1'b0;
    end else if (step) begin
      if (COUNT_W'(idx_r) < COUNT_MAX) begin
        mod_nxt = (s >= 5'd10) ? 4'(s - 5'd10) : s[3:0];
        if (digit != 4'd0) begin
          cnt_nxt   = COUNT_W'(idx_r) + 1'b1;
          lead1_nxt = digit;
          lead2_nxt = prev_r;
        end
      end else if (digit != 4'd0) begin
        ovf_nxt = 1'b1;
      end
      prev_nxt = digit;
      idx_nxt  = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mod_r   <= mod_nxt;
    cnt_r   <= cnt_nxt;
    lead1_r <= lead1_nxt;
    lead2_r <= lead2_nxt;
    prev_r  <= prev_nxt;
    ovf_r   <= ovf_nxt;
  end

  assign res.ovf   = ovf_r;
  assign res.mod   = mod_r;
  assign res.count = cnt_r;
  assign res.lead1 = lead1_r;
  assign res.lead2 = lead2_r;
  assign walk_last = step && (idx_r == IDX_W'(NUM_BCD - 1));

endmodule

>>> hw/rtl/luhn_card_number_classifier_core.sv
// ----------------------------------------------------------------------------
// luhn_card_number_classifier_core
// Mod-10 check and class decode of one binary card number.
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall with in_card_number (63 bit binary).
// result channel: out_valid / out_stall with out_luhn_ok, out_card_class and
// out_digit_count; each input transaction gives exactly one result.
// a transaction runs in three phases on the shared digit datapath:
//   binary to bcd conversion (4 bits per cycle),
//   digit walk (one digit per cycle through the luhn accumulator),
//   class decode into the output register.
// in_stall is high from the cycle after an input transaction until the
// result is placed in the output register. a new input can be taken while a
// finished result is still waiting on out_stall; it then holds in the decode
// phase until the output register frees up.
// synchronous reset empties the output register and returns to idle.
// ----------------------------------------------------------------------------
module luhn_card_number_classifier_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [lcc_pkg::CARD_W-1:0] in_card_number,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_luhn_ok,
  output logic [1:0]                 out_card_class,
  output logic [lcc_pkg::COUNT_W-1:0] out_digit_count
);
  import lcc_pkg::*;

  lcc_state_t   state_r, state_nxt;
  conv_ctl_t    ctl;
  logic         walk_step;
  logic         out_load;
  logic [3:0]   digit;
  logic         conv_last;
  logic         walk_last;
  luhn_res_t    res;
  logic         ok;
  card_class_t  cls;
  logic [COUNT_W-1:0] count;

  logic               out_valid_r, out_valid_nxt;
  logic               ok_r;
  card_class_t        cls_r;
  logic [COUNT_W-1:0] count_r;

  lcc_bcd_conv u_conv (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .card_number (in_card_number),
    .digit       (digit),
    .conv_last   (conv_last)
  );

  lcc_digit_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (ctl.load),
    .step      (walk_step),
    .digit     (digit),
    .res       (res),
    .walk_last (walk_last)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    ctl        = '0;
    walk_step  = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        ctl.dabble = 1'b1;
        if (conv_last) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        ctl.shr   = 1'b1;
        walk_step = 1'b1;
        if (walk_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // class decode
  always_comb begin
    ok    = (res.count != '0) && !res.ovf && (res.mod == 4'd0);
    count = res.ovf ? COUNT_MAX : res.count;
    cls   = CLS_INVALID;
    if (ok) begin
      if (res.count == COUNT_15 && res.lead1 == 4'd3 &&
          (res.lead2 == 4'd4 || res.lead2 == 4'd7)) begin
        cls = CLS_FIFTEEN;
      end else if (res.count == COUNT_16 && res.lead1 == 4'd5 &&
                   res.lead2 >= 4'd1 && res.lead2 <= 4'd5) begin
        cls = CLS_SIXTEEN;
      end else if ((res.count == COUNT_13 || res.count == COUNT_16) &&
                   res.lead1 == 4'd4) begin
        cls = CLS_LEAD4;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      ok_r    <= ok;
      cls_r   <= cls;
      count_r <= count;
    end
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_luhn_ok     = ok_r;
  assign out_card_class  = cls_r;
  assign out_digit_count = count_r;

endmodule

>>> hw/rtl/lcc_checker.sv
// ----------------------------------------------------------------------------
// lcc_checker
// Port-level checks of the card number classifier, bound to the top level.
// ----------------------------------------------------------------------------
module lcc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_luhn_ok,
  input logic [1:0]                  out_card_class,
  input logic [lcc_pkg::COUNT_W-1:0] out_digit_count
);
  import lcc_pkg::*;

  // busy right after an input transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a transaction is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_card_class) &&
      $stable(out_luhn_ok) && $stable(out_digit_count)))
    else $error("stalled result changed");

  a_class_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_card_class != CLS_INVALID) |-> out_luhn_ok)
    else $error("class given without luhn pass");

  a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_luhn_ok) |-> (out_digit_count != '0))
    else $error("luhn pass on zero number");

  a_fifteen_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_card_class == CLS_FIFTEEN) |-> (out_digit_count == COUNT_15))
    else $error("fifteen digit class with wrong count");

endmodule

bind luhn_card_number_classifier_core lcc_checker u_lcc_checker (.*);
